FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text cell writer
// Command codes, controller states, the front-to-back queue entry and the
// status that the back part reports to the front part.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen coordinates after clipping always fit in one byte (grid is at most 255 x 255).
	localparam int COORD_W     = 8;
	localparam int MAX_DIGITS  = 5;
	localparam int DIG_CNT_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	// Reciprocal of ten for 16-bit operands: n / 10 == (n * 52429) >> 19.
	localparam logic [15:0] RECIP_TEN = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	typedef enum logic [1:0] {
		CMD_PUT  = 2'd0,
		CMD_FILL = 2'd1,
		CMD_NUM  = 2'd2,
		CMD_READ = 2'd3
	} tcw_cmd_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIGIT,
		FR_PUSH
	} tcw_fstate_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RECT,
		BK_NUM,
		BK_READ,
		BK_DONE
	} tcw_bstate_t;

	// One classified request. For put and fill, x0..x1-1 by y0..y1-1 is the clipped
	// rectangle and rect_ok says it is not empty. For a number, y0 is the row and
	// rect_ok says that row is on the grid. For a read, x0/y0 is the cell.
	typedef struct packed {
		tcw_cmd_t                         cmd;
		logic                             start_in;
		logic                             rect_ok;
		logic [COORD_W-1:0]               x0;
		logic [COORD_W-1:0]               x1;
		logic [COORD_W-1:0]               y0;
		logic [COORD_W-1:0]               y1;
		logic [7:0]                       glyph;
		logic [7:0]                       attr;
		logic signed [15:0]               num_col;
		logic [MAX_DIGITS-1:0][3:0]       digits;
		logic [DIG_CNT_W-1:0]             ndig;
	} tcw_entry_t;

	typedef struct packed {
		logic clearing;
	} tcw_status_t;

endpackage

FILE: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: request intake and classification
// Registers a request, converts a number to decimal digits one digit per cycle
// and clips coordinates against the grid before handing an entry to the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
	parameter int COLUMNS   = 80,
	parameter int ROW_COUNT = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          command,
	input  logic signed [15:0]  col,
	input  logic signed [15:0]  row,
	input  logic [14:0]         width,
	input  logic [14:0]         height,
	input  logic [7:0]          glyph,
	input  logic [7:0]          color_attr,
	input  logic [15:0]         number,
	input  tcw_pkg::tcw_status_t status,
	output logic                push,
	output tcw_pkg::tcw_entry_t push_entry,
	input  logic                q_full
);

	localparam logic signed [16:0] COLS_S = 17'(COLUMNS);
	localparam logic signed [16:0] ROWS_S = 17'(ROW_COUNT);

	tcw_pkg::tcw_fstate_t fstate_q, fstate_d;

	tcw_pkg::tcw_cmd_t    cmd_q;
	logic signed [15:0]   col_q, row_q;
	logic [14:0]          width_q, height_q;
	logic [7:0]           glyph_q, attr_q;
	logic [15:0]          n_q;
	logic [tcw_pkg::MAX_DIGITS-1:0][3:0] digits_q;
	logic [tcw_pkg::DIG_CNT_W-1:0]       ndig_q;

	logic                 accept;
	logic [31:0]          prod;
	logic [12:0]          quot;
	logic [15:0]          quot_x10;
	logic [3:0]           digit;

	logic signed [16:0]   col_s, row_s, x_end, y_end, x0c, y0c, x1c, y1c;
	logic                 col_in, row_in, start_in, rect_fill;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (fstate_q != tcw_pkg::FR_IDLE) || status.clearing;

	// One decimal digit per cycle by reciprocal multiplication.
	assign prod     = n_q * tcw_pkg::RECIP_TEN;
	assign quot     = prod[31:tcw_pkg::RECIP_SHIFT];
	assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign digit    = 4'(n_q - quot_x10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q <= tcw_pkg::FR_IDLE;
		end else begin
			fstate_q <= fstate_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= tcw_pkg::tcw_cmd_t'(command);
			col_q    <= col;
			row_q    <= row;
			width_q  <= width;
			height_q <= height;
			glyph_q  <= glyph;
			attr_q   <= color_attr;
			n_q      <= number;
			ndig_q   <= '0;
		end else if (fstate_q == tcw_pkg::FR_DIGIT) begin
			digits_q[ndig_q] <= digit;
			ndig_q           <= ndig_q + 1'b1;
			n_q              <= 16'(quot);
		end
	end

	always_comb begin
		fstate_d = fstate_q;
		push     = 1'b0;
		unique case (fstate_q)
			tcw_pkg::FR_IDLE: begin
				if (accept) begin
					fstate_d = (tcw_pkg::tcw_cmd_t'(command) == tcw_pkg::CMD_NUM) ?
						tcw_pkg::FR_DIGIT : tcw_pkg::FR_PUSH;
				end
			end
			tcw_pkg::FR_DIGIT: begin
				if (quot == '0) begin
					fstate_d = tcw_pkg::FR_PUSH;
				end
			end
			tcw_pkg::FR_PUSH: begin
				if (!q_full) begin
					push     = 1'b1;
					fstate_d = tcw_pkg::FR_IDLE;
				end
			end
			default: fstate_d = tcw_pkg::FR_IDLE;
		endcase
	end

	// Clipping of the starting cell and of the fill rectangle.
	always_comb begin
		col_s     = {col_q[15], col_q};
		row_s     = {row_q[15], row_q};
		x_end     = col_s + $signed({2'b00, width_q});
		y_end     = row_s + $signed({2'b00, height_q});
		x0c       = col_s[16] ? '0 : col_s;
		y0c       = row_s[16] ? '0 : row_s;
		x1c       = (x_end > COLS_S) ? COLS_S : x_end;
		y1c       = (y_end > ROWS_S) ? ROWS_S : y_end;
		rect_fill = (x0c < x1c) && (y0c < y1c);
		col_in    = !col_s[16] && (col_s < COLS_S);
		row_in    = !row_s[16] && (row_s < ROWS_S);
		start_in  = col_in && row_in;
	end

	always_comb begin
		push_entry          = '0;
		push_entry.cmd      = cmd_q;
		push_entry.start_in = start_in;
		push_entry.glyph    = glyph_q;
		push_entry.attr     = attr_q;
		push_entry.num_col  = col_q;
		push_entry.digits   = digits_q;
		push_entry.ndig     = ndig_q;
		unique case (cmd_q)
			tcw_pkg::CMD_PUT: begin
				push_entry.x0      = col_q[7:0];
				push_entry.x1      = col_q[7:0] + 8'd1;
				push_entry.y0      = row_q[7:0];
				push_entry.y1      = row_q[7:0] + 8'd1;
				push_entry.rect_ok = start_in;
			end
			tcw_pkg::CMD_FILL: begin
				push_entry.x0      = x0c[7:0];
				push_entry.x1      = x1c[7:0];
				push_entry.y0      = y0c[7:0];
				push_entry.y1      = y1c[7:0];
				push_entry.rect_ok = rect_fill;
			end
			tcw_pkg::CMD_NUM: begin
				push_entry.y0      = row_q[7:0];
				push_entry.rect_ok = row_in;
			end
			tcw_pkg::CMD_READ: begin
				push_entry.x0      = col_q[7:0];
				push_entry.y0      = row_q[7:0];
				push_entry.rect_ok = start_in;
			end
			default: push_entry.rect_ok = 1'b0;
		endcase
	end

endmodule

FILE: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: short entry queue between front and back
// A small register FIFO; the head entry is presented while the queue is not empty.
// ----------------------------------------------------------------------------
module tcw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tcw_pkg::tcw_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output tcw_pkg::tcw_entry_t head,
	output logic                empty
);

	localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;

	tcw_pkg::tcw_entry_t slot_q [tcw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]      count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == (PTR_W+1)'(tcw_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(tcw_pkg::QUEUE_DEPTH))
		else $error("queue count exceeds its depth");

	a_push_when_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && push && !pop) |=> full)
		else $error("queue lost its full state on a refused push");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue pop did not release an entry");

endmodule

FILE: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: cell store and command execution
// Holds the cell store, clears it after reset, writes one cell per cycle for
// puts, fills and numbers, serves reads and registers the result.
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int COLUMNS   = 80,
	parameter int ROW_COUNT = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  tcw_pkg::tcw_entry_t  head,
	output logic                 pop,
	output tcw_pkg::tcw_status_t status,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [7:0]           glyph_read,
	output logic [7:0]           attr_read,
	output logic                 in_bounds,
	output logic [10:0]          cells_written
);

	localparam int CELLS = COLUMNS * ROW_COUNT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic signed [16:0] COLS_S = 17'(COLUMNS);

	tcw_pkg::tcw_bstate_t state_q, state_d;
	tcw_pkg::tcw_entry_t  ent_q;

	logic [15:0]   mem_q [CELLS];
	logic [15:0]   rd_data_q;
	logic [AW-1:0] clr_q;

	logic [tcw_pkg::COORD_W-1:0]   cur_x_q, cur_y_q;
	logic [tcw_pkg::COORD_W-1:0]   nx, ny;
	logic [tcw_pkg::DIG_CNT_W-1:0] m_q, dig_idx;
	logic [10:0]                   cnt_q;

	logic                 we, re;
	logic [AW-1:0]        addr;
	logic [15:0]          wdata;
	logic [tcw_pkg::COORD_W-1:0] ax, ay;
	logic signed [16:0]   num_x;
	logic                 num_on;
	logic                 load_res;

	assign status.clearing = (state_q == tcw_pkg::BK_CLEAR);

	assign nx      = cur_x_q + 1'b1;
	assign ny      = cur_y_q + 1'b1;
	assign num_x   = {ent_q.num_col[15], ent_q.num_col} + $signed({14'd0, m_q});
	assign num_on  = ent_q.rect_ok && !num_x[16] && (num_x < COLS_S);
	assign dig_idx = ent_q.ndig - 1'b1 - m_q;
	assign load_res = (state_q == tcw_pkg::BK_DONE) && (!res_valid || !res_stall);

	// Cell address mux and write/read enables.
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		wdata = {ent_q.attr, ent_q.glyph};
		ax    = cur_x_q;
		ay    = cur_y_q;
		unique case (state_q)
			tcw_pkg::BK_CLEAR: begin
				we    = 1'b1;
				wdata = '0;
			end
			tcw_pkg::BK_RECT: begin
				we = 1'b1;
			end
			tcw_pkg::BK_NUM: begin
				we    = num_on;
				ax    = num_x[7:0];
				ay    = ent_q.y0;
				wdata = {ent_q.attr, tcw_pkg::ASCII_DIGIT_HI, ent_q.digits[dig_idx]};
			end
			tcw_pkg::BK_READ: begin
				re = ent_q.start_in;
				ax = ent_q.x0;
				ay = ent_q.y0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		if (state_q == tcw_pkg::BK_CLEAR) begin
			addr = clr_q;
		end else begin
			addr = AW'(int'(ay) * COLUMNS + int'(ax));
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tcw_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			tcw_pkg::BK_CLEAR: begin
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = tcw_pkg::BK_IDLE;
				end
			end
			tcw_pkg::BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (head.cmd) inside
						tcw_pkg::CMD_PUT, tcw_pkg::CMD_FILL:
							state_d = head.rect_ok ? tcw_pkg::BK_RECT : tcw_pkg::BK_DONE;
						tcw_pkg::CMD_NUM:  state_d = tcw_pkg::BK_NUM;
						tcw_pkg::CMD_READ: state_d = tcw_pkg::BK_READ;
						default:           state_d = tcw_pkg::BK_DONE;
					endcase
				end
			end
			tcw_pkg::BK_RECT: begin
				if ((nx == ent_q.x1) && (ny == ent_q.y1)) begin
					state_d = tcw_pkg::BK_DONE;
				end
			end
			tcw_pkg::BK_NUM: begin
				if (m_q + 1'b1 == ent_q.ndig) begin
					state_d = tcw_pkg::BK_DONE;
				end
			end
			tcw_pkg::BK_READ: begin
				state_d = tcw_pkg::BK_DONE;
			end
			tcw_pkg::BK_DONE: begin
				if (load_res) begin
					state_d = tcw_pkg::BK_IDLE;
				end
			end
			default: state_d = tcw_pkg::BK_IDLE;
		endcase
	end

	// Per-command working registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q   <= head;
			cur_x_q <= head.x0;
			cur_y_q <= head.y0;
			m_q     <= '0;
			cnt_q   <= '0;
		end else begin
			if (state_q == tcw_pkg::BK_RECT) begin
				cnt_q <= cnt_q + 1'b1;
				if (nx == ent_q.x1) begin
					cur_x_q <= ent_q.x0;
					cur_y_q <= ny;
				end else begin
					cur_x_q <= nx;
				end
			end
			if (state_q == tcw_pkg::BK_NUM) begin
				m_q <= m_q + 1'b1;
				if (num_on) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load_res) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			if ((ent_q.cmd == tcw_pkg::CMD_READ) && ent_q.start_in) begin
				glyph_read <= rd_data_q[7:0];
				attr_read  <= rd_data_q[15:8];
			end else begin
				glyph_read <= '0;
				attr_read  <= '0;
			end
			in_bounds     <= ent_q.start_in;
			cells_written <= cnt_q;
		end
	end

	a_write_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (32'(addr) < CELLS))
		else $error("cell write outside the store");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == tcw_pkg::BK_IDLE))
		else $error("queue popped while a command is in progress");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::BK_NUM) |->
			(ent_q.ndig != '0) && (ent_q.ndig <= 3'(tcw_pkg::MAX_DIGITS)))
		else $error("number command with an impossible digit count");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> ($past(state_q) == tcw_pkg::BK_DONE))
		else $error("result presented outside the completion state");

endmodule

FILE: rtl/text_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_cell_writer_unit: text-mode cell store writer
// Executes put, fill, decimal number and read requests on a character and
// attribute cell grid and returns one result per request.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the whole cell store to zero, one cell per cycle;
// req_stall stays high during the sweep. A request then goes through a front
// part, which registers it, converts a number into its decimal digits (one to
// five), and then clips coordinates and hands the entry to a two-entry queue.
// The back part, which owns the single-port cell store, takes the entry and
// writes one cell per cycle: a put writes its one cell, a fill every cell left
// after clipping, a number each of its digits that lies on the grid; a read
// makes one store access. The completion state then moves the result into the
// output register once that register is free. The store write port therefore
// sets the rate: a request occupies the back part while its cells are written,
// and the front part may already classify the next request. Results come out
// in request order; an output register decouples the result side so the back
// part finishes its work while a previous result waits.
// ----------------------------------------------------------------------------
module text_cell_writer_unit #(
	parameter int COLUMNS   = 80,
	parameter int ROW_COUNT = 25
) (
	input  logic               clk,
	input  logic               arst_n,

	// Request channel.
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         command,
	input  logic signed [15:0] col,
	input  logic signed [15:0] row,
	input  logic [14:0]        width,
	input  logic [14:0]        height,
	input  logic [7:0]         glyph,
	input  logic [7:0]         color_attr,
	input  logic [15:0]        number,

	// Result channel.
	output logic               res_valid,
	input  logic               res_stall,
	output logic [7:0]         glyph_read,
	output logic [7:0]         attr_read,
	output logic               in_bounds,
	output logic [10:0]        cells_written
);

	tcw_pkg::tcw_status_t status;
	tcw_pkg::tcw_entry_t  push_entry;
	tcw_pkg::tcw_entry_t  head;
	logic                 push, q_full, pop, q_empty;

	// The front part registers a request, expands numbers into digits and clips
	// the target area, then pushes a classified entry.
	tcw_front #(
		.COLUMNS   (COLUMNS),
		.ROW_COUNT (ROW_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.command    (command),
		.col        (col),
		.row        (row),
		.width      (width),
		.height     (height),
		.glyph      (glyph),
		.color_attr (color_attr),
		.number     (number),
		.status     (status),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// The queue lets the front part classify the next request while the back
	// part is still writing cells for the previous one.
	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	// The back part owns the cell store and produces the results.
	tcw_back #(
		.COLUMNS   (COLUMNS),
		.ROW_COUNT (ROW_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.status        (status),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.glyph_read    (glyph_read),
		.attr_read     (attr_read),
		.in_bounds     (in_bounds),
		.cells_written (cells_written)
	);

	// No request is taken while the store is being cleared.
	a_stall_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> req_stall)
		else $error("request accepted during the store clearing sweep");

	// A write result never reports more cells than the grid holds.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (32'(cells_written) <= COLUMNS * ROW_COUNT))
		else $error("written cell count exceeds the grid size");

	// A read result never claims data for a cell outside the grid.
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !in_bounds) |-> (glyph_read == '0) && (attr_read == '0))
		else $error("off-grid request returned cell data");

endmodule

FILE: test/tb_text_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_text_cell_writer_unit: self-checking bench for the text cell writer
// Sends put, fill, number and read requests with random gaps on the request
// side and random stalls on the result side. A private copy of the cell grid
// predicts every result, and each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_text_cell_writer_unit;

	localparam int GRID_COLS       = 80;
	localparam int GRID_ROWS       = 25;
	localparam int RANDOM_REQUESTS = 1300;
	// The last requests of the run go out with no gaps and no stalls.
	localparam int QUIET_TAIL      = 200;
	// Cycles with no handshake on either side before the run is abandoned.
	// The slowest legitimate stretch is the clearing sweep after reset or a
	// full-screen fill.
	localparam int HANDSHAKE_LIMIT = 12000;
	localparam int DRAIN_CYCLES    = 40;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef struct {
		tcw_pkg::tcw_cmd_t  cmd;
		logic signed [15:0] col;
		logic signed [15:0] row;
		logic [14:0]        width;
		logic [14:0]        height;
		logic [7:0]         glyph;
		logic [7:0]         attr;
		logic [15:0]        number;
	} cell_request_t;

	typedef struct {
		logic [7:0]  glyph;
		logic [7:0]  attr;
		logic        inb;
		logic [10:0] count;
	} cell_result_t;

	// Keeps its own copy of the cell grid, works out the result of every
	// accepted request and holds those results until the block returns them.
	class cell_grid_model;
		logic [15:0]  cells [GRID_COLS*GRID_ROWS];
		cell_result_t expected_q [$];
		int           mismatches;
		int           cells_total;
		int           per_cmd [4];

		function new();
			foreach (cells[i]) cells[i] = '0;
			foreach (per_cmd[i]) per_cmd[i] = 0;
			mismatches  = 0;
			cells_total = 0;
		endfunction

		function bit on_grid(int x, int y);
			return x >= 0 && y >= 0 && x < GRID_COLS && y < GRID_ROWS;
		endfunction

		function int store_cell(int x, int y, logic [7:0] g, logic [7:0] a);
			if (!on_grid(x, y))
				return 0;
			cells[y*GRID_COLS + x] = {a, g};
			return 1;
		endfunction

		function void note_request(cell_request_t r);
			int           x, y, w, h, x0, y0, x1, y1, i, j, k, n, count;
			logic [3:0]   digits [tcw_pkg::MAX_DIGITS];
			cell_result_t res;
			x         = r.col;
			y         = r.row;
			w         = r.width;
			h         = r.height;
			count     = 0;
			res.glyph = '0;
			res.attr  = '0;
			res.inb   = on_grid(x, y);
			case (r.cmd)
				tcw_pkg::CMD_PUT: begin
					count = store_cell(x, y, r.glyph, r.attr);
				end
				tcw_pkg::CMD_FILL: begin
					// Clip the rectangle to the grid first; anything left is written.
					x0 = (x < 0) ? 0 : x;
					y0 = (y < 0) ? 0 : y;
					x1 = (x + w > GRID_COLS) ? GRID_COLS : x + w;
					y1 = (y + h > GRID_ROWS) ? GRID_ROWS : y + h;
					for (j = y0; j < y1; j++)
						for (i = x0; i < x1; i++)
							count += store_cell(i, j, r.glyph, r.attr);
				end
				tcw_pkg::CMD_NUM: begin
					// Digits are collected least significant first and written
					// the other way round, each one clipped on its own.
					n = r.number;
					k = 0;
					if (n == 0) begin
						digits[0] = '0;
						k         = 1;
					end else begin
						while (n != 0) begin
							digits[k] = 4'(n % 10);
							n         = n / 10;
							k++;
						end
					end
					for (i = 0; i < k; i++)
						count += store_cell(x + i, y, CHAR_ZERO + 8'(digits[k-1-i]), r.attr);
				end
				default: begin
					if (res.inb)
						{res.attr, res.glyph} = cells[y*GRID_COLS + x];
				end
			endcase
			res.count = 11'(count);
			per_cmd[r.cmd]++;
			cells_total += count;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, logic [10:0] want, logic [10:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(cell_result_t got);
			cell_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, actual %0d/%0d/%0d/%0d",
					$time, got.glyph, got.attr, got.inb, got.count);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("glyph_read", want.glyph, got.glyph);
			compare_field("attr_read", want.attr, got.attr);
			compare_field("in_bounds", want.inb, got.inb);
			compare_field("cells_written", want.count, got.count);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         command;
	logic signed [15:0] col;
	logic signed [15:0] row;
	logic [14:0]        width;
	logic [14:0]        height;
	logic [7:0]         glyph;
	logic [7:0]         color_attr;
	logic [15:0]        number;
	logic               res_valid;
	logic               res_stall;
	logic [7:0]         glyph_read;
	logic [7:0]         attr_read;
	logic               in_bounds;
	logic [10:0]        cells_written;

	cell_grid_model grid;
	bit             quiet_tail = 1'b0;
	int             idle_cycles = 0;

	text_cell_writer_unit #(
		.COLUMNS   (GRID_COLS),
		.ROW_COUNT (GRID_ROWS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.command       (command),
		.col           (col),
		.row           (row),
		.width         (width),
		.height        (height),
		.glyph         (glyph),
		.color_attr    (color_attr),
		.number        (number),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.glyph_read    (glyph_read),
		.attr_read     (attr_read),
		.in_bounds     (in_bounds),
		.cells_written (cells_written)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Presents one request at a falling edge, possibly after an idle burst,
	// and holds it until a rising edge finds the stall low. The model sees the
	// request at the edge that accepts it. Valid is only touched once per
	// falling edge, so back-to-back requests keep it high without a glitch.
	task automatic send_request(input cell_request_t r);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid  <= 1'b1;
		command    <= r.cmd;
		col        <= r.col;
		row        <= r.row;
		width      <= r.width;
		height     <= r.height;
		glyph      <= r.glyph;
		color_attr <= r.attr;
		number     <= r.number;
		do
			@(posedge clk);
		while (req_stall);
		grid.note_request(r);
	endtask

	// Every field starts out random, so fields that a command ignores are
	// exercised as well; callers override what the command really uses.
	function automatic cell_request_t random_fields();
		cell_request_t r;
		r.cmd    = tcw_pkg::CMD_READ;
		r.col    = 16'($urandom);
		r.row    = 16'($urandom);
		r.width  = 15'($urandom);
		r.height = 15'($urandom);
		r.glyph  = 8'($urandom);
		r.attr   = 8'($urandom);
		r.number = 16'($urandom);
		return r;
	endfunction

	task automatic directed(input tcw_pkg::tcw_cmd_t cmd, input int c, input int rw,
			input int w, input int h, input int g, input int a, input int n);
		cell_request_t r;
		r        = random_fields();
		r.cmd    = cmd;
		r.col    = 16'(c);
		r.row    = 16'(rw);
		r.width  = 15'(w);
		r.height = 15'(h);
		r.glyph  = 8'(g);
		r.attr   = 8'(a);
		r.number = 16'(n);
		send_request(r);
	endtask

	function automatic cell_request_t random_request();
		cell_request_t r;
		int            pick;
		r    = random_fields();
		pick = $urandom_range(0, 99);
		if (pick < 25)
			r.cmd = tcw_pkg::CMD_PUT;
		else if (pick < 50)
			r.cmd = tcw_pkg::CMD_FILL;
		else if (pick < 70)
			r.cmd = tcw_pkg::CMD_NUM;
		else
			r.cmd = tcw_pkg::CMD_READ;
		// Most requests land on the grid or just beside it; the rest keep the
		// full coordinate range so that every bit of col and row toggles.
		if ($urandom_range(0, 9) != 0) begin
			r.col = 16'(int'($urandom_range(0, GRID_COLS + 5)) - 3);
			r.row = 16'(int'($urandom_range(0, GRID_ROWS + 4)) - 2);
		end
		if (r.cmd == tcw_pkg::CMD_FILL) begin
			// Fills are written cell by cell, so most of them are small. A few
			// keep the full 15-bit sizes and may cover the whole screen.
			pick = $urandom_range(0, 19);
			if (pick < 16) begin
				r.width  = 15'($urandom_range(0, 6));
				r.height = 15'($urandom_range(0, 4));
			end else if (pick < 19) begin
				r.width  = 15'($urandom_range(0, GRID_COLS + 10));
				r.height = 15'($urandom_range(0, GRID_ROWS + 4));
			end
		end
		if (r.cmd == tcw_pkg::CMD_NUM && $urandom_range(0, 3) == 0)
			r.number = 16'($urandom_range(0, 120));
		return r;
	endfunction

	// Result side: stall in random bursts, and not at all during the tail.
	initial begin
		int burst;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 8);
				res_stall <= 1'b1;
				repeat (burst) @(negedge clk);
			end
			res_stall <= 1'b0;
		end
	end

	// Results are taken at the rising edge, where the block's registered
	// outputs still hold the values of the cycle that just ended.
	always @(posedge clk) begin : result_monitor
		cell_result_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.glyph = glyph_read;
			got.attr  = attr_read;
			got.inb   = in_bounds;
			got.count = cells_written;
			grid.check_result(got);
		end
	end

	// Watchdog: the run is abandoned if neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANDSHAKE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results still outstanding",
					$time, idle_cycles, grid.expected_q.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		cell_request_t      r;
		int                 i;
		logic signed [15:0] last_col;
		logic signed [15:0] last_row;
		grid       = new();
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		command    = tcw_pkg::CMD_PUT;
		col        = '0;
		row        = '0;
		width      = '0;
		height     = '0;
		glyph      = '0;
		color_attr = '0;
		number     = '0;
		last_col   = '0;
		last_row   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The block holds the request stall high while it sweeps
		// the store after reset, so the first request simply waits for that.
		// A read of a cell nobody has written yet must return zero.
		directed(tcw_pkg::CMD_READ, 0, 0, $urandom, $urandom, $urandom, $urandom, $urandom);
		// Puts at both corners with the extreme glyph and attribute values,
		// then puts that fall off each side of the grid.
		directed(tcw_pkg::CMD_PUT, 0, 0, $urandom, $urandom, 8'hff, 8'hff, $urandom);
		directed(tcw_pkg::CMD_PUT, GRID_COLS - 1, GRID_ROWS - 1, $urandom, $urandom,
			8'h00, 8'h00, $urandom);
		directed(tcw_pkg::CMD_PUT, GRID_COLS, 0, $urandom, $urandom, 8'h41, 8'h17, $urandom);
		directed(tcw_pkg::CMD_PUT, -1, 5, $urandom, $urandom, 8'h42, 8'h27, $urandom);
		directed(tcw_pkg::CMD_PUT, 5, -32768, $urandom, $urandom, 8'h43, 8'h37, $urandom);
		directed(tcw_pkg::CMD_PUT, 32767, 32767, $urandom, $urandom, 8'h44, 8'h47, $urandom);
		directed(tcw_pkg::CMD_READ, 0, 0, $urandom, $urandom, $urandom, $urandom, $urandom);
		directed(tcw_pkg::CMD_READ, GRID_COLS - 1, GRID_ROWS - 1, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		// A fill with zero width or zero height writes nothing.
		directed(tcw_pkg::CMD_FILL, 10, 10, 0, 5, 8'h2a, 8'h70, $urandom);
		directed(tcw_pkg::CMD_FILL, 10, 10, 5, 0, 8'h2a, 8'h70, $urandom);
		// Largest sizes from the most negative corner still end left of the grid.
		directed(tcw_pkg::CMD_FILL, -32768, -32768, 32767, 32767, 8'h2b, 8'h71, $urandom);
		// Largest sizes from just outside the grid cover all of it.
		directed(tcw_pkg::CMD_FILL, -10, -3, 32767, 32767, 8'hdb, 8'h1e, $urandom);
		// Screen clear: the whole grid filled with spaces.
		directed(tcw_pkg::CMD_FILL, 0, 0, GRID_COLS, GRID_ROWS, CHAR_SPACE, 8'h07, $urandom);
		// A fill that hangs over the bottom right corner.
		directed(tcw_pkg::CMD_FILL, GRID_COLS - 4, GRID_ROWS - 3, 10, 10, 8'hb0, 8'h4e,
			$urandom);
		// Number zero gives a single digit; the largest number runs off the
		// right edge; another starts left of the grid; one lies below it.
		directed(tcw_pkg::CMD_NUM, 3, 3, $urandom, $urandom, $urandom, 8'h0a, 0);
		directed(tcw_pkg::CMD_NUM, GRID_COLS - 3, 10, $urandom, $urandom, $urandom, 8'h0b,
			65535);
		directed(tcw_pkg::CMD_NUM, -2, 4, $urandom, $urandom, $urandom, 8'h0c, 12345);
		directed(tcw_pkg::CMD_NUM, 0, GRID_ROWS, $urandom, $urandom, $urandom, 8'h0d, 999);
		// Read back what the numbers left behind, and read off the grid on
		// two sides.
		directed(tcw_pkg::CMD_READ, GRID_COLS - 3, 10, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		directed(tcw_pkg::CMD_READ, GRID_COLS - 1, 10, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		directed(tcw_pkg::CMD_READ, 0, 4, $urandom, $urandom, $urandom, $urandom, $urandom);
		directed(tcw_pkg::CMD_READ, 3, 3, $urandom, $urandom, $urandom, $urandom, $urandom);
		directed(tcw_pkg::CMD_READ, -1, 0, $urandom, $urandom, $urandom, $urandom, $urandom);
		directed(tcw_pkg::CMD_READ, 0, GRID_ROWS, $urandom, $urandom, $urandom, $urandom,
			$urandom);

		// Random part. Half of the reads go back to where the last write
		// started, so that stored contents are checked soon after they change.
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - QUIET_TAIL)
				quiet_tail = 1'b1;
			r = random_request();
			if (r.cmd == tcw_pkg::CMD_READ && $urandom_range(0, 1) == 1) begin
				r.col = last_col;
				r.row = last_row;
			end
			send_request(r);
			if (r.cmd != tcw_pkg::CMD_READ) begin
				last_col = r.col;
				last_row = r.row;
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (grid.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d puts, %0d fills, %0d numbers, %0d reads.",
			grid.per_cmd[tcw_pkg::CMD_PUT] + grid.per_cmd[tcw_pkg::CMD_FILL]
			+ grid.per_cmd[tcw_pkg::CMD_NUM] + grid.per_cmd[tcw_pkg::CMD_READ],
			grid.per_cmd[tcw_pkg::CMD_PUT], grid.per_cmd[tcw_pkg::CMD_FILL],
			grid.per_cmd[tcw_pkg::CMD_NUM], grid.per_cmd[tcw_pkg::CMD_READ]);
		$display("They wrote %0d cells in total; %0d field mismatches were seen.",
			grid.cells_total, grid.mismatches);
		if (grid.mismatches == 0 && grid.expected_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_cell_writer_unit.sv
test/tb_text_cell_writer_unit.sv
